>>> design/jsu_pkg.sv
package jsu_pkg;

    // Width of the written-byte counter
    localparam int LEN_W = 16;
    // Width used for the room check; holds any counter plus a group
    localparam int CMP_W = 33;
    localparam logic [CMP_W-1:0] LEN_MAX = (CMP_W'(1) << LEN_W) - CMP_W'(1);

    localparam int CAP_W = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    // Status codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CAPACITY  = 3'd1;
    localparam logic [2:0] ERR_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_HEX       = 3'd3;
    localparam logic [2:0] ERR_SURROGATE = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    // Input bytes with a meaning of their own
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // One queued group: up to three data bytes, or one status word
    typedef struct packed {
        logic             is_status;
        logic [2:0]       status;
        logic [15:0]      length;
        logic [1:0]       nbytes;
        logic [2:0][7:0]  bytes;
    } jsu_entry_t;

    // Hex digit decode; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
        return r;
    endfunction

    // Single-letter escape decode; bit 8 set means no such escape
    function automatic logic [8:0] esc_decode(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = 9'h022;
            8'h5C:   r = 9'h05C;
            8'h2F:   r = 9'h02F;
            8'h62:   r = 9'h008;
            8'h66:   r = 9'h00C;
            8'h6E:   r = 9'h00A;
            8'h72:   r = 9'h00D;
            8'h74:   r = 9'h009;
            default: r = 9'h100;
        endcase
        return r;
    endfunction

endpackage

>>> design/jsu_front.sv
module jsu_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [7:0]              in_byte,
    input  logic                    in_end,
    input  logic [15:0]             capacity,
    input  logic                    q_full,
    output logic                    in_ready,
    output logic                    push,
    output jsu_pkg::jsu_entry_t     push_entry
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX0,
        MODE_HEX1,
        MODE_HEX2,
        MODE_HEX3
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [15:0]      acc_reg, acc_next;
    logic [LEN_W-1:0] wc_reg, wc_next;
    logic [2:0]       err_reg, err_next;

    logic             accept;
    logic [4:0]       hex;
    logic [8:0]       esc;
    logic [15:0]      code;
    logic             grp_en;
    logic [1:0]       grp_n;
    logic [2:0][7:0]  grp_bytes;
    logic [CMP_W-1:0] need;
    logic [CMP_W-1:0] wc_ext;
    logic [2:0]       end_status;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign hex      = hex_decode(in_byte);
    assign esc      = esc_decode(in_byte);
    assign code     = {acc_reg[11:0], hex[3:0]};
    assign wc_ext   = CMP_W'(wc_reg);
    assign need     = wc_ext + CMP_W'(grp_n);

    // Status reported by the end marker
    always_comb
    begin
        end_status = err_reg;
        if (end_status == ERR_NONE && mode_reg != MODE_TEXT) end_status = ERR_TRUNCATED;
        if (end_status == ERR_NONE && capacity == '0)        end_status = ERR_CAPACITY;
    end

    // Decode: next state and the output group this byte asks for
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        wc_next   = wc_reg;
        err_next  = err_reg;
        grp_en    = 1'b0;
        grp_n     = 2'd1;
        grp_bytes = {8'h00, 8'h00, in_byte};
        push      = 1'b0;
        push_entry.is_status = 1'b0;
        push_entry.status    = ERR_NONE;
        push_entry.length    = 16'h0000;
        push_entry.nbytes    = grp_n;
        push_entry.bytes     = grp_bytes;

        if (in_end) begin
            mode_next = MODE_TEXT;
            acc_next  = '0;
            wc_next   = '0;
            err_next  = ERR_NONE;
        end else if (err_reg == ERR_NONE) begin
            case (mode_reg)
                MODE_TEXT:
                begin
                    if (in_byte == CH_BSLASH) mode_next = MODE_ESC;
                    else                      grp_en = 1'b1;
                end
                MODE_ESC:
                begin
                    mode_next = MODE_TEXT;
                    if (in_byte == CH_U) begin
                        mode_next = MODE_HEX0;
                        acc_next  = '0;
                    end else if (esc[8]) begin
                        err_next = ERR_ESCAPE;
                    end else begin
                        grp_en       = 1'b1;
                        grp_bytes[0] = esc[7:0];
                    end
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2:
                begin
                    if (hex[4]) begin
                        err_next  = ERR_HEX;
                        mode_next = MODE_TEXT;
                    end else begin
                        acc_next  = code;
                        mode_next = mode_t'(mode_reg + 3'd1);
                    end
                end
                MODE_HEX3:
                begin
                    mode_next = MODE_TEXT;
                    if (hex[4]) begin
                        err_next = ERR_HEX;
                    end else begin
                        acc_next = '0;
                        if (code >= 16'hD800 && code <= 16'hDFFF) begin
                            err_next = ERR_SURROGATE;
                        end else begin
                            grp_en = 1'b1;
                            if (code < 16'h0080) begin
                                grp_n     = 2'd1;
                                grp_bytes = {8'h00, 8'h00, code[7:0]};
                            end else if (code < 16'h0800) begin
                                grp_n     = 2'd2;
                                grp_bytes = {8'h00, {2'b10, code[5:0]},
                                             {3'b110, code[10:6]}};
                            end else begin
                                grp_n     = 2'd3;
                                grp_bytes = {{2'b10, code[5:0]}, {2'b10, code[11:6]},
                                             {4'hE, code[15:12]}};
                            end
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_TEXT;
                end
            endcase
        end

        // Room check; a group is written whole or not at all
        if (grp_en) begin
            if (need >= CMP_W'(capacity) || need > LEN_MAX) begin
                err_next = ERR_CAPACITY;
            end else begin
                wc_next = need[LEN_W-1:0];
                push    = accept;
            end
        end

        push_entry.nbytes = grp_n;
        push_entry.bytes  = grp_bytes;

        if (in_end) begin
            push                 = accept;
            push_entry.is_status = 1'b1;
            push_entry.status    = end_status;
            push_entry.length    = wc_ext[15:0];
            push_entry.nbytes    = 2'd1;
            push_entry.bytes     = '0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_TEXT;
            acc_reg  <= '0;
            wc_reg   <= '0;
            err_reg  <= ERR_NONE;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            wc_reg   <= wc_next;
            err_reg  <= err_next;
        end
    end

endmodule

>>> design/jsu_fifo.sv
module jsu_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  jsu_pkg::jsu_entry_t     push_entry,
    input  logic                    pop,
    output jsu_pkg::jsu_entry_t     head,
    output logic                    full,
    output logic                    empty
);
    import jsu_pkg::*;

    jsu_entry_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_reg;
    logic [FIFO_AW-1:0]   rd_reg;
    logic [FIFO_AW:0]     cnt_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_reg] <= push_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + FIFO_AW'(1);
            if (do_pop)  rd_reg <= rd_reg + FIFO_AW'(1);
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + (FIFO_AW+1)'(1);
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - (FIFO_AW+1)'(1);
        end
    end

endmodule

>>> design/jsu_back.sv
module jsu_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  jsu_pkg::jsu_entry_t     head,
    input  logic                    q_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    is_status,
    output logic [2:0]              status_code,
    output logic [15:0]             out_length,
    output logic                    last_of_run
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       taken;

    assign out_valid   = !q_empty;
    assign out_byte    = head.bytes[idx_reg];
    assign is_status   = head.is_status;
    assign status_code = head.status;
    assign out_length  = head.length;
    assign last_of_run = idx_reg == head.nbytes - 2'd1;
    assign taken       = out_valid && out_ready;
    assign pop         = taken && last_of_run;

    // Walk through the bytes of the head group
    always_comb
    begin
        idx_next = idx_reg;
        if (pop)        idx_next = 2'd0;
        else if (taken) idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) idx_reg <= 2'd0;
        else        idx_reg <= idx_next;
    end

endmodule

>>> design/json_string_unescape_utf8_core.sv
// A group made from an accepted word is registered in the queue before it reaches the master side.
// One input word per cycle while the queue is not full, and one output word per cycle while
// m_tready is high; a \u escape takes six input words for up to three output words through a
// four-entry group queue. Reset (rst_n low, asynchronous): text mode, counter and held error
// cleared, queue emptied, out_capacity back to 256.
module json_string_unescape_utf8_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [10:8] status_code, [26:11] out_length
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser,   // is_status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jsu_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    jsu_entry_t       push_entry;
    jsu_entry_t       head;
    logic [7:0]       out_byte;
    logic [2:0]       status_code;
    logic [15:0]      out_length;

    // Register port: out_capacity at addresses 0 to 3 (paddr[2] low)
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'h0000, cap_reg} : 32'h0000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .capacity   (cap_reg),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    jsu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (out_byte),
        .is_status   (m_tuser),
        .status_code (status_code),
        .out_length  (out_length),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {5'b00000, out_length, status_code, out_byte};

    // A status word always closes its run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status word without last");

    // Data words carry no status and no length
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[26:8] == 19'h0)
        else $error("data word with status fields set");

    // Queue cannot be full and empty together
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty");

    // A status group holds only one word
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> head.nbytes == 2'd1)
        else $error("status group longer than one word");

endmodule
